// File: design/sbgd_pkg.sv
// ----------------------------------------------------------------------------
// sbgd_pkg: shared definitions for the seven-bit group decoder
// Widths, character limits, controller states and the command/status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sbgd_pkg;

	localparam int GROUP_LEN = 12;
	localparam int CHAR_W    = 8;
	localparam int DIGIT_W   = 7;
	localparam int SEXTET_W  = 6;
	localparam int BYTE_W    = 8;
	localparam int BASE      = 91;
	localparam int IDX_W     = $clog2(GROUP_LEN + 2);
	localparam int PAIR_W    = $clog2(GROUP_LEN / 2 + 1);
	localparam int RAM_DEPTH = 2 * GROUP_LEN;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int V_W       = 14;
	localparam int TOP_BIT   = 12;
	localparam int QUAD      = 4;

	localparam logic [CHAR_W-1:0]  CHAR_FIRST = 8'd32;
	localparam logic [CHAR_W-1:0]  CHAR_END   = CHAR_W'(32 + BASE);
	localparam logic [DIGIT_W-1:0] MARK_DIGIT = DIGIT_W'(BASE - 1);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_WARN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ITEM_HI,
		ITEM_LO,
		ITEM_TOP
	} item_kind_t;

	typedef enum logic [1:0] {
		DEC_HELD,
		DEC_HELD_FLUSH,
		DEC_CURRENT
	} dec_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHAR,
		S_BAD,
		S_NEXT,
		S_RDA,
		S_RDB,
		S_VAL,
		S_PUSH,
		S_EMIT,
		S_GDONE,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic      capture;
		logic      write_digit;
		logic      set_term;
		logic      emit_bad;
		logic      dec_start;
		dec_mode_t dec_mode;
		logic      rd_a;
		logic      rd_b;
		logic      calc_v;
		logic      push;
		logic      emit_byte;
		logic      finish;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic       halted;
		logic       eoi;
		logic       bad_char;
		logic       mark_pair;
		logic       group_full;
		logic       held_valid;
		logic       fill_zero;
		logic       dec_done;
		item_kind_t item_kind;
		logic       dec_on_current;
		logic       emit_done;
		logic       can_emit;
		logic       pend_valid;
	} dp_sts_t;

	// Two digit banks share one RAM: bank 0 at 0..11, bank 1 at 12..23.
	function automatic logic [RAM_AW-1:0] ram_addr(logic bank, logic [IDX_W-1:0] idx);
		logic [RAM_AW-1:0] base_addr;
		base_addr = bank ? RAM_AW'(GROUP_LEN) : '0;
		return base_addr + RAM_AW'(idx);
	endfunction

endpackage

// File: design/seven_bit_group_decoder.sv
// ----------------------------------------------------------------------------
// seven_bit_group_decoder: base-91 character stream to binary bytes
// A character that does not finish a group is accepted, then stored. Finishing
// a group while one is held decodes the held group pair by pair, emitting its
// bytes as it goes; end of input decodes what remains. Reset clears all
// control state; digit stores need no clearing.
// ----------------------------------------------------------------------------
module seven_bit_group_decoder
	import sbgd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              end_of_input,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [1:0]        status,
	output logic              last
);

	// The block works on one input item at a time. The controller takes a
	// transfer only in its idle state, then stores the character into the
	// current digit bank of a shared two-bank RAM. When a group of twelve
	// digits is complete the banks swap roles, so the finished group becomes
	// the held group without any copy.
	//
	// Decoding a group walks it pair by pair through the single RAM read port:
	// two reads, one multiply-add for the base-91 value, then its sextets one
	// at a time into a four-entry carry. Every full carry, and the terminator
	// quad, hands its bytes to the output side one per cycle while that side has room.
	//
	// Results go through a pending slot ahead of the output register. A
	// result leaves the slot when the next one arrives or when the item is
	// finished, which is how the final result of an item gets its last flag.
	// The output register lets the decoder keep going while the downstream
	// side holds a result back, until the pending slot also holds one.

	dp_cmd_t cmd;
	dp_sts_t sts;

	sbgd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sbgd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.status       (status),
		.last         (last)
	);

`ifndef ASSERT_OFF
	// Once halted, the block never produces another result.
	halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		sts.halted |-> !(cmd.emit_byte || cmd.emit_bad))
		else $error("result produced while halted");

	// Every result of the previous item has left the pending slot before
	// a new input transfer is taken.
	pend_empty_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall) |-> !sts.pend_valid)
		else $error("input accepted with a result still pending");

	// A group decode never pushes more sextets than it was set up for.
	push_within_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.dec_done)
		else $error("sextet pushed past the end of the group");

	// A byte goes out only when the quad has bytes left and the slot is free.
	emit_guarded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte |-> (!sts.emit_done && sts.can_emit))
		else $error("byte emitted without room or beyond the quad");
`endif

endmodule

// File: design/sbgd_ram.sv
// ----------------------------------------------------------------------------
// sbgd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/sbgd_datapath.sv
// ----------------------------------------------------------------------------
// sbgd_datapath: digit storage, pair decode, sextet carry and result registers
// Executes the controller's commands and reports status back.
// ----------------------------------------------------------------------------
module sbgd_datapath
	import sbgd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              end_of_input,
	input  logic              result_stall,
	output logic              result_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [1:0]        status,
	output logic              last
);

	// Captured input item.
	logic [CHAR_W-1:0]  char_q;
	logic               eoi_q;

	// Group collection state.
	logic [IDX_W-1:0]   fill_q;
	logic               held_valid_q;
	logic               cur_bank_q;
	logic [DIGIT_W-1:0] term_q;
	logic               halted_q;
	logic               mark0_q;
	logic               mark01_q;

	// Sextet carry.
	logic [SEXTET_W-1:0] carry_q [QUAD];
	logic [1:0]          carry_fill_q;

	// Group decode state.
	logic                dec_bank_q;
	logic [IDX_W-1:0]    dec_n_q;
	logic [PAIR_W-1:0]   dec_pairs_q;
	logic [IDX_W-1:0]    dec_use_q;
	logic                dec_len_nz_q;
	logic [IDX_W-1:0]    idx_q;
	logic [DIGIT_W-1:0]  digit_a_q;
	logic [V_W-1:0]      v_q;
	logic [SEXTET_W-1:0] top_q;

	// Quad emission.
	logic [1:0]          nbytes_q;
	logic [1:0]          byte_cnt_q;
	status_t             emit_st_q;

	// Pending result and output register.
	logic                pend_valid_q;
	logic [BYTE_W-1:0]   pend_byte_q;
	logic                pend_bv_q;
	status_t             pend_st_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_bv_q;
	status_t             out_st_q;
	logic                out_last_q;

	logic [CHAR_W-1:0]   char_off;
	logic [DIGIT_W-1:0]  digit;
	logic                bad_char;
	logic [RAM_AW-1:0]   waddr;
	logic [RAM_AW-1:0]   raddr;
	logic [IDX_W-1:0]    rd_idx;
	logic [DIGIT_W-1:0]  rdata;
	logic                has_b;
	logic [DIGIT_W-1:0]  b_digit;
	logic [V_W-1:0]      v_next;

	logic                sel_bank;
	logic [IDX_W-1:0]    sel_n;
	logic [DIGIT_W-1:0]  sel_len;
	logic [IDX_W:0]      sel_np1;
	logic [PAIR_W-1:0]   sel_pairs;
	logic [IDX_W-1:0]    sel_items;
	logic [IDX_W-1:0]    sel_use;

	item_kind_t          item_kind;
	logic [SEXTET_W-1:0] item_val;
	logic                is_last;
	logic                quad_full;
	logic [1:0]          push_nbytes;
	status_t             push_st;
	logic                push_clear;

	logic [BYTE_W-1:0]   quad_b0;
	logic [BYTE_W-1:0]   quad_b1;
	logic [BYTE_W-1:0]   quad_b2;
	logic [BYTE_W-1:0]   cur_byte;
	logic                out_free;
	logic                emit_any;
	logic [BYTE_W-1:0]   new_byte;
	logic                new_bv;
	status_t             new_st;
	logic                load_out;

	// ---------------------------------------------------------------- decode
	assign char_off = char_q - CHAR_FIRST;
	assign digit    = char_off[DIGIT_W-1:0];
	assign bad_char = (char_q < CHAR_FIRST) || (char_q >= CHAR_END);

	assign waddr  = ram_addr(cur_bank_q, fill_q);
	assign rd_idx = cmd.rd_b ? {idx_q[IDX_W-1:1], 1'b1} : idx_q;
	assign raddr  = ram_addr(dec_bank_q, rd_idx);

	sbgd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write_digit),
		.waddr (waddr),
		.wdata (digit),
		.re    (cmd.rd_a | cmd.rd_b),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A missing second digit of an odd group reads as zero.
	assign has_b   = ({1'b0, idx_q} + 1'b1) < {1'b0, dec_n_q};
	assign b_digit = has_b ? rdata : '0;
	assign v_next  = V_W'(digit_a_q) * V_W'(BASE) + V_W'(b_digit);

	always_comb begin
		sel_bank = ~cur_bank_q;
		sel_n    = IDX_W'(GROUP_LEN);
		sel_len  = '0;
		unique case (cmd.dec_mode)
			DEC_HELD: begin
				sel_len = '0;
			end
			DEC_HELD_FLUSH: begin
				sel_len = (fill_q == '0) ? term_q : '0;
			end
			DEC_CURRENT: begin
				sel_bank = cur_bank_q;
				sel_n    = fill_q;
				sel_len  = term_q;
			end
			default: begin
				sel_len = '0;
			end
		endcase
	end

	assign sel_np1   = {1'b0, sel_n} + 1'b1;
	assign sel_pairs = PAIR_W'(sel_np1 >> 1);
	assign sel_items = IDX_W'({sel_pairs, 1'b1});
	assign sel_use   = ((sel_len != '0) && (sel_len < DIGIT_W'(sel_items))) ?
	                   IDX_W'(sel_len) : sel_items;

	always_comb begin
		if (idx_q < IDX_W'({dec_pairs_q, 1'b0})) begin
			item_kind = idx_q[0] ? ITEM_LO : ITEM_HI;
		end else begin
			item_kind = ITEM_TOP;
		end
	end

	always_comb begin
		unique case (item_kind)
			ITEM_HI:  item_val = v_q[2*SEXTET_W-1:SEXTET_W];
			ITEM_LO:  item_val = v_q[SEXTET_W-1:0];
			ITEM_TOP: item_val = top_q;
			default:  item_val = top_q;
		endcase
	end

	// The final item of a terminated group carries the byte count of its quad.
	assign is_last   = ({1'b0, idx_q} + 1'b1) == {1'b0, dec_use_q};
	assign quad_full = (carry_fill_q == 2'd3);

	always_comb begin
		push_nbytes = '0;
		push_st     = ST_OK;
		push_clear  = 1'b0;
		if (is_last && dec_len_nz_q) begin
			push_clear = 1'b1;
			if (item_val < SEXTET_W'(3)) begin
				push_nbytes = item_val[1:0];
			end else begin
				push_nbytes = 2'd3;
				push_st     = ST_WARN;
			end
		end else if (quad_full) begin
			push_clear  = 1'b1;
			push_nbytes = 2'd3;
		end
	end

	assign quad_b0 = {carry_q[0], carry_q[1][5:4]};
	assign quad_b1 = {carry_q[1][3:0], carry_q[2][5:2]};
	assign quad_b2 = {carry_q[2][1:0], carry_q[3]};

	always_comb begin
		case (byte_cnt_q)
			2'd0:    cur_byte = quad_b0;
			2'd1:    cur_byte = quad_b1;
			default: cur_byte = quad_b2;
		endcase
	end

	// ---------------------------------------------------------------- status
	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		sts.halted         = halted_q;
		sts.eoi            = eoi_q;
		sts.bad_char       = bad_char;
		sts.mark_pair      = (fill_q == IDX_W'(2)) && mark01_q;
		sts.group_full     = (fill_q == IDX_W'(GROUP_LEN - 1));
		sts.held_valid     = held_valid_q;
		sts.fill_zero      = (fill_q == '0);
		sts.dec_done       = (idx_q == dec_use_q);
		sts.item_kind      = item_kind;
		sts.dec_on_current = (dec_bank_q == cur_bank_q);
		sts.emit_done      = (byte_cnt_q == nbytes_q);
		sts.can_emit       = !pend_valid_q || out_free;
		sts.pend_valid     = pend_valid_q;
	end

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
			eoi_q  <= 1'b0;
		end else if (cmd.capture) begin
			char_q <= in_char;
			eoi_q  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			held_valid_q <= 1'b0;
			cur_bank_q   <= 1'b0;
			term_q       <= '0;
			halted_q     <= 1'b0;
			mark0_q      <= 1'b0;
			mark01_q     <= 1'b0;
		end else begin
			if (cmd.clear) begin
				fill_q       <= '0;
				held_valid_q <= 1'b0;
				term_q       <= '0;
				halted_q     <= 1'b0;
			end
			if (cmd.emit_bad) begin
				halted_q <= 1'b1;
			end
			if (cmd.set_term) begin
				term_q <= digit;
				fill_q <= '0;
			end
			if (cmd.write_digit) begin
				if (fill_q == '0) begin
					mark0_q <= (digit == MARK_DIGIT);
				end
				if (fill_q == IDX_W'(1)) begin
					mark01_q <= mark0_q && (digit == MARK_DIGIT);
				end
				if (fill_q == IDX_W'(GROUP_LEN - 1)) begin
					fill_q       <= '0;
					held_valid_q <= 1'b1;
					cur_bank_q   <= ~cur_bank_q;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_bank_q   <= 1'b0;
			dec_n_q      <= '0;
			dec_pairs_q  <= '0;
			dec_use_q    <= '0;
			dec_len_nz_q <= 1'b0;
			idx_q        <= '0;
			top_q        <= '0;
		end else begin
			if (cmd.dec_start) begin
				dec_bank_q   <= sel_bank;
				dec_n_q      <= sel_n;
				dec_pairs_q  <= sel_pairs;
				dec_use_q    <= sel_use;
				dec_len_nz_q <= (sel_len != '0);
				idx_q        <= '0;
				top_q        <= '0;
			end
			if (cmd.calc_v) begin
				top_q <= {top_q[SEXTET_W-2:0], v_next[TOP_BIT]};
			end
			if (cmd.push) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_b) begin
			digit_a_q <= rdata;
		end
		if (cmd.calc_v) begin
			v_q <= v_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUAD; i++) begin
				carry_q[i] <= '0;
			end
			carry_fill_q <= '0;
			nbytes_q     <= '0;
			byte_cnt_q   <= '0;
			emit_st_q    <= ST_OK;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < QUAD; i++) begin
					carry_q[i] <= '0;
				end
				carry_fill_q <= '0;
			end
			if (cmd.push) begin
				carry_q[carry_fill_q] <= item_val;
				carry_fill_q          <= push_clear ? 2'd0 : carry_fill_q + 1'b1;
				nbytes_q              <= push_nbytes;
				emit_st_q             <= push_st;
				byte_cnt_q            <= '0;
			end
			if (cmd.emit_byte) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------- result staging
	// A new result waits in the pending slot until either another result
	// follows (it leaves with last low) or the item finishes (last high).
	assign emit_any = cmd.emit_byte | cmd.emit_bad;
	assign new_byte = cmd.emit_bad ? '0 : cur_byte;
	assign new_bv   = !cmd.emit_bad;
	assign new_st   = cmd.emit_bad ? ST_BAD : emit_st_q;
	assign load_out = (emit_any && pend_valid_q) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_any) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			pend_byte_q <= new_byte;
			pend_bv_q   <= new_bv;
			pend_st_q   <= new_st;
		end
		if (load_out) begin
			out_byte_q <= pend_byte_q;
			out_bv_q   <= pend_bv_q;
			out_st_q   <= pend_st_q;
			out_last_q <= cmd.finish;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = out_bv_q;
	assign status       = out_st_q;
	assign last         = out_last_q;

endmodule

// File: design/sbgd_ctrl.sv
// ----------------------------------------------------------------------------
// sbgd_ctrl: controller state machine of the seven-bit group decoder
// Sequences character handling, group decode and result hand-off.
// ----------------------------------------------------------------------------
module sbgd_ctrl
	import sbgd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	output logic    char_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	// Picks the next step of a group decode from the item counter.
	function automatic ctrl_state_t dispatch(dp_sts_t s);
		ctrl_state_t nxt;
		if (s.dec_done) begin
			nxt = S_GDONE;
		end else if (s.item_kind == ITEM_HI) begin
			nxt = S_RDA;
		end else begin
			nxt = S_PUSH;
		end
		return nxt;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					state_next = S_CHAR;
				end
			end
			S_CHAR: begin
				if (sts.halted) begin
					state_next = S_IDLE;
				end else if (sts.eoi) begin
					state_next = (sts.held_valid || !sts.fill_zero) ? S_NEXT : S_FIN;
				end else if (sts.bad_char) begin
					state_next = S_BAD;
				end else if (sts.mark_pair) begin
					state_next = S_IDLE;
				end else if (sts.group_full && sts.held_valid) begin
					state_next = S_NEXT;
				end else begin
					state_next = S_IDLE;
				end
			end
			S_BAD: begin
				if (sts.can_emit) begin
					state_next = S_FIN;
				end
			end
			S_NEXT:  state_next = dispatch(sts);
			S_RDA:   state_next = S_RDB;
			S_RDB:   state_next = S_VAL;
			S_VAL:   state_next = S_PUSH;
			S_PUSH:  state_next = S_EMIT;
			S_EMIT: begin
				if (sts.emit_done) begin
					state_next = dispatch(sts);
				end
			end
			S_GDONE: begin
				if (sts.eoi && !sts.dec_on_current && !sts.fill_zero) begin
					state_next = S_NEXT;
				end else begin
					state_next = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.pend_valid || sts.can_emit) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		char_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				char_stall  = 1'b0;
				cmd.capture = char_valid;
			end
			S_CHAR: begin
				if (sts.halted) begin
					cmd.capture = 1'b0;
				end else if (sts.eoi) begin
					if (sts.held_valid) begin
						cmd.dec_start = 1'b1;
						cmd.dec_mode  = DEC_HELD_FLUSH;
					end else if (!sts.fill_zero) begin
						cmd.dec_start = 1'b1;
						cmd.dec_mode  = DEC_CURRENT;
					end else begin
						cmd.clear = 1'b1;
					end
				end else if (sts.bad_char) begin
					cmd.capture = 1'b0;
				end else if (sts.mark_pair) begin
					cmd.set_term = 1'b1;
				end else begin
					cmd.write_digit = 1'b1;
					if (sts.group_full && sts.held_valid) begin
						cmd.dec_start = 1'b1;
						cmd.dec_mode  = DEC_HELD;
					end
				end
			end
			S_BAD: begin
				cmd.emit_bad = sts.can_emit;
			end
			S_RDA:  cmd.rd_a   = 1'b1;
			S_RDB:  cmd.rd_b   = 1'b1;
			S_VAL:  cmd.calc_v = 1'b1;
			S_PUSH: cmd.push   = 1'b1;
			S_EMIT: begin
				cmd.emit_byte = !sts.emit_done && sts.can_emit;
			end
			S_GDONE: begin
				if (sts.eoi && !sts.dec_on_current && !sts.fill_zero) begin
					cmd.dec_start = 1'b1;
					cmd.dec_mode  = DEC_CURRENT;
				end else if (sts.eoi) begin
					cmd.clear = 1'b1;
				end
			end
			S_FIN: begin
				cmd.finish = sts.pend_valid && sts.can_emit;
			end
			S_NEXT: begin
				cmd.capture = 1'b0;
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

endmodule
